[design/pnps_pkg.sv]
package pnps_pkg;

    // number of register stages from input request to output register
    localparam int NS = 32;

    typedef enum logic [1:0] {
        CFG_X_STEP     = 2'd0,
        CFG_Y_STEP     = 2'd1,
        CFG_BRIGHT_OFS = 2'd2
    } t_cfg_idx;

    localparam logic [15:0] X_STEP_RST = 16'd16384;
    localparam logic [15:0] Y_STEP_RST = 16'd26214;
    localparam logic [15:0] OFS_RST    = 16'd13107;

    localparam logic [8:0]  PERIOD        = 9'd289;
    localparam logic [9:0]  PERIOD_X2     = 10'd578;
    localparam logic [9:0]  PERIOD_X3     = 10'd867;
    localparam logic [23:0] PERIOD_RECIP  = 24'd14861478;  // floor(2^32 / 289)
    localparam logic [15:0] SEVENTH_RECIP = 16'd37450;     // ceil(2^18 / 7)

    localparam logic signed [17:0] HALF_Q16   = 18'sd32768;
    localparam logic signed [17:0] ONE_Q16    = 18'sd65536;
    localparam logic signed [21:0] FADE_A_OFS = 22'sd983040;   // 15.0
    localparam logic signed [21:0] FADE_B_OFS = 22'sd655360;   // 10.0
    localparam logic signed [17:0] TAYLOR_A   = 18'sd117496;
    localparam logic [15:0]        TAYLOR_B   = 16'd55950;
    localparam logic [17:0]        SCALE_22   = 18'd144179;
    localparam logic signed [17:0] NV_MAX     = 18'sd131071;
    localparam logic signed [17:0] NV_MIN     = -18'sd131072;

    typedef struct packed {
        logic [2:0][15:0] f0;    // fractions x, y, z
        logic [2:0][17:0] fd;    // faded fractions, signed q.16
        logic [1:0][8:0]  lay;
        logic [1:0][8:0]  laz;
    } t_carry;

    typedef struct packed {
        logic signed [17:0] gx;
        logic signed [17:0] gy;
        logic signed [17:0] gz;
    } t_grad;

    // round a q.32 product back to q.16, half up
    function automatic logic signed [31:0] f_rnd(input logic signed [47:0] v);
        logic signed [47:0] w;
        w = (v + 48'sd32768) >>> 16;
        return w[31:0];
    endfunction

    function automatic logic [23:0] f_hash_mul(input logic [9:0] v);
        logic [14:0] k;
        k = 15'(v) * 15'd34 + 15'd1;
        return 24'(k) * 24'(v);
    endfunction

    function automatic logic [15:0] f_hash_quo(input logic [23:0] m);
        logic [47:0] p;
        p = 48'(m) * 48'(PERIOD_RECIP);
        return p[47:32];
    endfunction

    function automatic logic [8:0] f_hash_rem(input logic [23:0] m, input logic [15:0] q);
        logic [23:0] r;
        r = m - 24'(q) * 24'(PERIOD);
        if (r >= 24'(PERIOD)) begin
            r = r - 24'(PERIOD);
        end
        return r[8:0];
    endfunction

    function automatic logic [5:0] f_div7(input logic [8:0] h);
        logic [24:0] p;
        p = 25'(h) * 25'(SEVENTH_RECIP);
        return p[23:18];
    endfunction

    function automatic logic [15:0] f_seventh(input logic [2:0] k);
        logic [15:0] s;
        case (k)
            3'd0: s = 16'd0;
            3'd1: s = 16'd9362;
            3'd2: s = 16'd18725;
            3'd3: s = 16'd28087;
            3'd4: s = 16'd37449;
            3'd5: s = 16'd46811;
            3'd6: s = 16'd56174;
            default: s = 16'd0;
        endcase
        return s;
    endfunction

endpackage

[design/perlin_noise_pixel_shader.sv]
// Per-pixel shader: for each pixel (column, row, time) it evaluates 3D classic gradient noise
// at (column*x_step, row*y_step, time) with lattice period 289, scales it by 2.2 and returns
// the noise in signed Q1.16 plus an 8-bit brightness clamp((n+1)/2 - offset, 0, 1)^2 * 255.
// The datapath is a fully pipelined chain of 32 register stages, so a pixel can be taken on
// every clock unless the output holds back a full pipeline. Each stage holds its item until
// the next one frees up, so bubbles close up and a new request is taken while a finished
// result still waits on the output. Configuration registers are read live by the first and
// the brightness stages and are meant to be written while no pixel is in flight.
module perlin_noise_pixel_shader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // pixel requests
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [3:0] column, [7:4] row, [33:8] time_coord
    // results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [17:0] noise_value, [25:18] brightness
);
    import pnps_pkg::*;

    // config registers
    logic [15:0] r_x_step, r_y_step, r_ofs;

    // pipeline control: a stage loads when it is empty or its successor loads
    logic [1:NS]   r_vld;
    logic [1:NS+1] en;

    // side data carried with each item
    t_carry r_cy [2:NS];
    t_carry n_cy [2:NS];

    // stage 1: scaled point
    logic [19:0] r_px, r_py;
    logic [25:0] r_pz;

    // fade path
    logic signed [37:0] r_ta  [3];
    logic [31:0]        r_tt  [3];
    logic signed [21:0] r_fb  [3];
    logic signed [21:0] r_fb4 [3];
    logic [33:0]        r_t3p [3];
    logic [16:0]        r_t3  [3];
    logic signed [39:0] r_fdp [3];

    // hash path
    logic [8:0]  r_lx  [2];
    logic [23:0] r_hm1 [2];
    logic [23:0] r_hm1b[2];
    logic [15:0] r_hq1 [2];
    logic [8:0]  r_hx  [2];
    logic [23:0] r_hm2 [4];
    logic [23:0] r_hm2b[4];
    logic [15:0] r_hq2 [4];
    logic [8:0]  r_hxy [4];
    logic [23:0] r_hm3 [8];
    logic [23:0] r_hm3b[8];
    logic [15:0] r_hq3 [8];
    logic [8:0]  r_h   [8];

    // gradient path
    logic [5:0]         r_q7 [8];
    logic [2:0]         r_r7 [8];
    t_grad              r_g  [13:17][8];
    t_grad              n_g  [8];
    logic signed [35:0] r_sq [8];
    logic [17:0]        r_rr [8];
    logic [33:0]        r_nmp[8];
    logic signed [17:0] r_nm [8];
    logic signed [35:0] r_gp [8][3];
    logic signed [18:0] r_gn [8][3];
    logic signed [37:0] r_dp [8];
    logic signed [21:0] r_n  [8];

    // trilinear mix
    logic signed [43:0] r_mzp[4];
    logic signed [23:0] r_mza[4];
    logic signed [23:0] r_m  [4];
    logic signed [43:0] r_myp[2];
    logic signed [23:0] r_mya[2];
    logic signed [23:0] r_p  [2];
    logic signed [43:0] r_mxp;
    logic signed [23:0] r_mxa;
    logic signed [23:0] r_r;

    // scale and brightness
    logic signed [43:0] r_sp;
    logic signed [17:0] r_nv29, r_nv30, r_nv31, r_nv32;
    logic signed [17:0] n_nv29;
    logic [16:0]        r_uv;
    logic [16:0]        n_uv;
    logic [32:0]        r_sq2;
    logic [7:0]         r_bright;
    logic [40:0]        n_bp;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_step <= X_STEP_RST;
            r_y_step <= Y_STEP_RST;
            r_ofs    <= OFS_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_X_STEP:     r_x_step <= i_cfg_data;
                CFG_Y_STEP:     r_y_step <= i_cfg_data;
                CFG_BRIGHT_OFS: r_ofs    <= i_cfg_data;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    always_comb begin
        en[NS+1] = i_m_axis_tready;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_s_axis_tvalid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = en[1];
    assign o_m_axis_tvalid = r_vld[NS];
    assign o_m_axis_tdata  = {6'd0, r_bright, r_nv32};

    // ---------------- carried side data ----------------
    always_comb begin
        logic [9:0] iz;
        logic [8:0] lz;
        iz = r_pz[25:16];
        // integer part of z mod 289, at most three periods above
        if (iz >= PERIOD_X3) begin
            lz = 9'(iz - PERIOD_X3);
        end else if (iz >= PERIOD_X2) begin
            lz = 9'(iz - PERIOD_X2);
        end else if (iz >= 10'(PERIOD)) begin
            lz = 9'(iz - 10'(PERIOD));
        end else begin
            lz = iz[8:0];
        end
        n_cy[2].f0[0] = r_px[15:0];
        n_cy[2].f0[1] = r_py[15:0];
        n_cy[2].f0[2] = r_pz[15:0];
        n_cy[2].fd    = '0;
        n_cy[2].lay[0] = {5'd0, r_py[19:16]};
        n_cy[2].lay[1] = {5'd0, r_py[19:16]} + 9'd1;
        n_cy[2].laz[0] = lz;
        n_cy[2].laz[1] = (lz == PERIOD - 9'd1) ? 9'd0 : lz + 9'd1;
        for (int k = 3; k <= NS; k++) begin
            n_cy[k] = r_cy[k-1];
        end
        for (int a = 0; a < 3; a++) begin
            n_cy[6].fd[a] = 18'(f_rnd(48'(r_fdp[a])));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 2; k <= NS; k++) begin
            if (en[k]) begin
                r_cy[k] <= n_cy[k];
            end
        end
    end

    // ---------------- gradient selection ----------------
    always_comb begin
        logic [5:0]         q49;
        logic [2:0]         r49;
        logic signed [17:0] gx0, gy0, agy, gz0;
        for (int c = 0; c < 8; c++) begin
            q49 = f_div7({3'd0, r_q7[c]});
            r49 = 3'(r_q7[c] - q49 * 6'd7);
            gx0 = $signed({2'd0, f_seventh(r_r7[c])});
            gy0 = $signed({2'd0, f_seventh(r49)}) - HALF_Q16;
            agy = (gy0 < 0) ? -gy0 : gy0;
            gz0 = HALF_Q16 - gx0 - agy;
            n_g[c].gz = gz0;
            if (gz0 <= 0) begin
                // fold the octahedron corners back in
                n_g[c].gx = gx0 - HALF_Q16;
                n_g[c].gy = (gy0 >= 0) ? gy0 - HALF_Q16 : gy0 + HALF_Q16;
            end else begin
                n_g[c].gx = gx0;
                n_g[c].gy = gy0;
            end
        end
    end

    // ---------------- scale saturation and brightness ----------------
    always_comb begin
        logic signed [31:0] s;
        logic signed [18:0] h, v;
        s = f_rnd(48'(r_sp));
        if (s > 32'(NV_MAX)) begin
            n_nv29 = NV_MAX;
        end else if (s < 32'(NV_MIN)) begin
            n_nv29 = NV_MIN;
        end else begin
            n_nv29 = 18'(s);
        end
        h = 19'(r_nv29) + 19'(ONE_Q16);
        if (h < 0) begin
            v = '0;
        end else begin
            v = (h >>> 1) - $signed({3'd0, r_ofs});
        end
        if (v < 0) begin
            n_uv = '0;
        end else if (v > 19'(ONE_Q16)) begin
            n_uv = 17'(ONE_Q16);
        end else begin
            n_uv = 17'(v);
        end
        n_bp = {r_sq2, 8'd0} - 41'(r_sq2);   // times 255
    end

    // ---------------- datapath stages ----------------
    always_ff @(posedge i_clk) begin
        logic [15:0]        t;
        logic signed [21:0] fa;
        logic [16:0]        t2;
        logic [9:0]         hv;
        logic signed [17:0] fsel [3];
        logic signed [24:0] d;

        // s1: point
        if (en[1]) begin
            r_px <= 20'(i_s_axis_tdata[3:0]) * 20'(r_x_step);
            r_py <= 20'(i_s_axis_tdata[7:4]) * 20'(r_y_step);
            r_pz <= i_s_axis_tdata[33:8];
        end

        // s2: lattice x, fade products
        if (en[2]) begin
            r_lx[0] <= {5'd0, r_px[19:16]};
            r_lx[1] <= {5'd0, r_px[19:16]} + 9'd1;
            for (int a = 0; a < 3; a++) begin
                t = n_cy[2].f0[a];
                fa = $signed(22'(t) * 22'd6) - FADE_A_OFS;
                r_ta[a] <= $signed(38'(t)) * 38'(fa);
                r_tt[a] <= 32'(t) * 32'(t);
            end
        end

        // s3
        if (en[3]) begin
            for (int a = 0; a < 3; a++) begin
                t2 = 17'(f_rnd(48'(r_tt[a])));
                r_fb[a]  <= 22'(f_rnd(48'(r_ta[a]))) + FADE_B_OFS;
                r_t3p[a] <= 34'(t2) * 34'(r_cy[2].f0[a]);
            end
            for (int j = 0; j < 2; j++) begin
                r_hm1[j] <= f_hash_mul({1'b0, r_lx[j]});
            end
        end

        // s4
        if (en[4]) begin
            for (int a = 0; a < 3; a++) begin
                r_t3[a]  <= 17'(f_rnd(48'(r_t3p[a])));
                r_fb4[a] <= r_fb[a];
            end
            for (int j = 0; j < 2; j++) begin
                r_hq1[j]  <= f_hash_quo(r_hm1[j]);
                r_hm1b[j] <= r_hm1[j];
            end
        end

        // s5
        if (en[5]) begin
            for (int a = 0; a < 3; a++) begin
                r_fdp[a] <= $signed({1'b0, r_t3[a]}) * r_fb4[a];
            end
            for (int j = 0; j < 2; j++) begin
                r_hx[j] <= f_hash_rem(r_hm1b[j], r_hq1[j]);
            end
        end

        // s6-s8: second hash level
        if (en[6]) begin
            for (int j = 0; j < 4; j++) begin
                hv = 10'(r_hx[j % 2]) + 10'(r_cy[5].lay[j / 2]);
                r_hm2[j] <= f_hash_mul(hv);
            end
        end
        if (en[7]) begin
            for (int j = 0; j < 4; j++) begin
                r_hq2[j]  <= f_hash_quo(r_hm2[j]);
                r_hm2b[j] <= r_hm2[j];
            end
        end
        if (en[8]) begin
            for (int j = 0; j < 4; j++) begin
                r_hxy[j] <= f_hash_rem(r_hm2b[j], r_hq2[j]);
            end
        end

        // s9-s11: third hash level, one lane per corner
        if (en[9]) begin
            for (int c = 0; c < 8; c++) begin
                hv = 10'(r_hxy[c % 4]) + 10'(r_cy[8].laz[c / 4]);
                r_hm3[c] <= f_hash_mul(hv);
            end
        end
        if (en[10]) begin
            for (int c = 0; c < 8; c++) begin
                r_hq3[c]  <= f_hash_quo(r_hm3[c]);
                r_hm3b[c] <= r_hm3[c];
            end
        end
        if (en[11]) begin
            for (int c = 0; c < 8; c++) begin
                r_h[c] <= f_hash_rem(r_hm3b[c], r_hq3[c]);
            end
        end

        // s12: h / 7 and h mod 7
        if (en[12]) begin
            for (int c = 0; c < 8; c++) begin
                r_q7[c] <= f_div7(r_h[c]);
                r_r7[c] <= 3'(r_h[c] - 9'(f_div7(r_h[c])) * 9'd7);
            end
        end

        // s13: gradient vector
        if (en[13]) begin
            r_g[13] <= n_g;
        end
        for (int k = 14; k <= 17; k++) begin
            if (en[k]) begin
                r_g[k] <= r_g[k-1];
            end
        end

        // s14-s17: taylor inverse square root
        if (en[14]) begin
            for (int c = 0; c < 8; c++) begin
                r_sq[c] <= r_g[13][c].gx * r_g[13][c].gx + r_g[13][c].gy * r_g[13][c].gy
                         + r_g[13][c].gz * r_g[13][c].gz;
            end
        end
        if (en[15]) begin
            for (int c = 0; c < 8; c++) begin
                r_rr[c] <= 18'(f_rnd(48'(r_sq[c])));
            end
        end
        if (en[16]) begin
            for (int c = 0; c < 8; c++) begin
                r_nmp[c] <= 34'(r_rr[c]) * 34'(TAYLOR_B);
            end
        end
        if (en[17]) begin
            for (int c = 0; c < 8; c++) begin
                r_nm[c] <= TAYLOR_A - 18'(f_rnd(48'(r_nmp[c])));
            end
        end

        // s18-s19: normalized gradient
        if (en[18]) begin
            for (int c = 0; c < 8; c++) begin
                r_gp[c][0] <= r_g[17][c].gx * r_nm[c];
                r_gp[c][1] <= r_g[17][c].gy * r_nm[c];
                r_gp[c][2] <= r_g[17][c].gz * r_nm[c];
            end
        end
        if (en[19]) begin
            for (int c = 0; c < 8; c++) begin
                for (int a = 0; a < 3; a++) begin
                    r_gn[c][a] <= 19'(f_rnd(48'(r_gp[c][a])));
                end
            end
        end

        // s20-s21: dot with the offset to each corner
        if (en[20]) begin
            for (int c = 0; c < 8; c++) begin
                for (int a = 0; a < 3; a++) begin
                    fsel[a] = $signed({2'd0, r_cy[19].f0[a]});
                    if (c[a]) begin
                        fsel[a] = fsel[a] - ONE_Q16;
                    end
                end
                r_dp[c] <= r_gn[c][0] * fsel[0] + r_gn[c][1] * fsel[1]
                         + r_gn[c][2] * fsel[2];
            end
        end
        if (en[21]) begin
            for (int c = 0; c < 8; c++) begin
                r_n[c] <= 22'(f_rnd(48'(r_dp[c])));
            end
        end

        // s22-s27: mix along z, then y, then x
        if (en[22]) begin
            for (int i = 0; i < 4; i++) begin
                d = 25'(r_n[i+4]) - 25'(r_n[i]);
                r_mzp[i] <= d * $signed(r_cy[21].fd[2]);
                r_mza[i] <= 24'(r_n[i]);
            end
        end
        if (en[23]) begin
            for (int i = 0; i < 4; i++) begin
                r_m[i] <= r_mza[i] + 24'(f_rnd(48'(r_mzp[i])));
            end
        end
        if (en[24]) begin
            for (int i = 0; i < 2; i++) begin
                d = 25'(r_m[i+2]) - 25'(r_m[i]);
                r_myp[i] <= d * $signed(r_cy[23].fd[1]);
                r_mya[i] <= r_m[i];
            end
        end
        if (en[25]) begin
            for (int i = 0; i < 2; i++) begin
                r_p[i] <= r_mya[i] + 24'(f_rnd(48'(r_myp[i])));
            end
        end
        if (en[26]) begin
            d = 25'(r_p[1]) - 25'(r_p[0]);
            r_mxp <= d * $signed(r_cy[25].fd[0]);
            r_mxa <= r_p[0];
        end
        if (en[27]) begin
            r_r <= r_mxa + 24'(f_rnd(48'(r_mxp)));
        end

        // s28-s29: scale by 2.2 and saturate
        if (en[28]) begin
            r_sp <= 44'(r_r) * $signed(44'(SCALE_22));
        end
        if (en[29]) begin
            r_nv29 <= n_nv29;
        end

        // s30-s32: brightness
        if (en[30]) begin
            r_uv   <= n_uv;
            r_nv30 <= r_nv29;
        end
        if (en[31]) begin
            r_sq2  <= 33'(r_uv) * 33'(r_uv);
            r_nv31 <= r_nv30;
        end
        if (en[32]) begin
            r_bright <= n_bp[39:32];
            r_nv32   <= r_nv31;
        end
    end

    // ---------------- checks ----------------
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_vld[1])
        else $error("accepted request not captured in first stage");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (&r_vld) && !i_m_axis_tready)
        else $error("request blocked while pipeline has a free slot");

    a_mid_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[16] && !en[17] |=> r_vld[16])
        else $error("stalled item dropped from middle stage");

    a_dark_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (r_nv32 < -ONE_Q16) |-> r_bright == 8'd0)
        else $error("nonzero brightness for noise below -1");

endmodule

[sim/tb_perlin_noise_pixel_shader.sv]
module tb_perlin_noise_pixel_shader;

    localparam int        LAT       = pnps_pkg::NS;
    localparam int        STALL_MAX = 20000;
    localparam logic [1:0] CFG_NONE = 2'd3;   // index with no register behind it

    localparam longint SEVENTH_Q16 [7] = '{0, 9362, 18725, 28087, 37449, 46811, 56174};

    typedef struct {
        logic [3:0]  col;
        logic [3:0]  row;
        logic [25:0] tc;
    } t_pixel;

    typedef struct {
        logic signed [17:0] nv;
        logic [7:0]         bright;
    } t_shade;

    typedef struct {
        t_pixel px;
        bit     known;      // expectation typed in below
        t_shade shade;
    } t_vec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;

    // shadow copy of the step and offset registers
    logic [15:0] step_x, step_y, bright_ofs;

    t_shade shade_q[$];
    int     err_cnt = 0;
    int     quiet_cycles = 0;
    bit     steady = 1'b0;   // no idling on either side while set

    always #4 i_clk = ~i_clk;

    perlin_noise_pixel_shader u_top (.*);

    // ---------------------------------------------------------------- predictor

    function automatic longint rnd_q16(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic int unsigned perm289(int unsigned x);
        return ((34 * x + 1) * x) % 289;
    endfunction

    function automatic longint fade_q16(longint t);
        longint a, b, t2, t3;
        a  = 6 * t - 15 * 65536;
        b  = rnd_q16(t * a) + 10 * 65536;
        t2 = rnd_q16(t * t);
        t3 = rnd_q16(t2 * t);
        return rnd_q16(t3 * b);
    endfunction

    function automatic longint lerp_q16(longint a, longint b, longint f);
        return a + rnd_q16((b - a) * f);
    endfunction

    function automatic t_shade shade_pixel(t_pixel px);
        longint      pt [3];
        int unsigned lat [3][2];
        longint      f0 [3], f1 [3], fd [3], corner [8], m [4];
        longint      gx, gy, gz, agy, rr, nm, p0, p1, r, v;
        longint unsigned uv;
        int unsigned h, ip;
        int          bx, by, bz;
        t_shade      res;
        pt[0] = longint'(px.col) * step_x;
        pt[1] = longint'(px.row) * step_y;
        pt[2] = longint'(px.tc);
        for (int i = 0; i < 3; i++) begin
            ip        = int'(pt[i] >> 16) % 289;
            lat[i][0] = ip;
            lat[i][1] = (ip + 1) % 289;
            f0[i]     = pt[i] & 16'hFFFF;
            f1[i]     = f0[i] - 65536;
            fd[i]     = fade_q16(f0[i]);
        end
        for (int c = 0; c < 8; c++) begin
            bx  = c & 1;
            by  = (c >> 1) & 1;
            bz  = (c >> 2) & 1;
            h   = perm289(perm289(perm289(lat[0][bx]) + lat[1][by]) + lat[2][bz]);
            gx  = SEVENTH_Q16[h % 7];
            gy  = SEVENTH_Q16[(h / 7) % 7] - 32768;
            agy = gy < 0 ? -gy : gy;
            gz  = 32768 - gx - agy;
            // fold gradients that fall outside the octahedron
            if (gz <= 0) begin
                gx = gx - 32768;
                gy = (gy >= 0) ? gy - 32768 : gy + 32768;
            end
            rr = rnd_q16(gx * gx + gy * gy + gz * gz);
            nm = 117496 - rnd_q16(55950 * rr);
            gx = rnd_q16(gx * nm);
            gy = rnd_q16(gy * nm);
            gz = rnd_q16(gz * nm);
            corner[c] = rnd_q16(gx * (bx ? f1[0] : f0[0]) + gy * (by ? f1[1] : f0[1])
                                + gz * (bz ? f1[2] : f0[2]));
        end
        for (int i = 0; i < 4; i++) begin
            m[i] = lerp_q16(corner[i], corner[i + 4], fd[2]);
        end
        p0 = lerp_q16(m[0], m[2], fd[1]);
        p1 = lerp_q16(m[1], m[3], fd[1]);
        r  = rnd_q16(lerp_q16(p0, p1, fd[0]) * 144179);
        if (r > 131071) r = 131071;
        if (r < -131072) r = -131072;
        res.nv = r[17:0];
        // brightness: halve to [0,1], subtract offset, clamp, square
        v = r + 65536;
        v = (v < 0) ? 0 : (v >>> 1) - longint'(bright_ofs);
        if (v < 0) v = 0;
        if (v > 65536) v = 65536;
        uv = v;
        res.bright = 8'((uv * uv * 255) >> 32);
        return res;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            pnps_pkg::CFG_X_STEP:     step_x     = val;
            pnps_pkg::CFG_Y_STEP:     step_y     = val;
            pnps_pkg::CFG_BRIGHT_OFS: bright_ofs = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // wait until the pipe has drained before touching the registers
    task automatic drain();
        wait (shade_q.size() == 0);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic send_pixel(t_pixel px, bit known, t_shade shade);
        while (!steady && $urandom_range(99) < 32) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'b0, px.tc, px.row, px.col};
        do @(posedge i_clk); while (!o_s_axis_tready);
        shade_q.push_back(known ? shade : shade_pixel(px));
    endtask

    function automatic t_pixel rand_pixel();
        t_pixel px;
        px.col = 4'($urandom_range(15));
        px.row = 4'($urandom_range(15));
        case ($urandom_range(3))
            0: px.tc = 26'($urandom_range(1023) << 16);     // on the time lattice
            1: px.tc = 26'($urandom_range(65535));          // near zero
            default: px.tc = 26'($urandom());
        endcase
        return px;
    endfunction

    // ---------------------------------------------------------------- result check

    always @(posedge i_clk) begin
        t_shade exp_s;
        i_m_axis_tready <= steady || ($urandom_range(99) >= 32);
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (shade_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_m_axis_tdata);
                err_cnt++;
            end else begin
                exp_s = shade_q.pop_front();
                if (o_m_axis_tdata[17:0] !== exp_s.nv) begin
                    $display("%0t: noise_value expected %0d actual %0d", $time,
                             exp_s.nv, $signed(o_m_axis_tdata[17:0]));
                    err_cnt++;
                end
                if (o_m_axis_tdata[25:18] !== exp_s.bright) begin
                    $display("%0t: brightness expected %0d actual %0d", $time,
                             exp_s.bright, o_m_axis_tdata[25:18]);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog: count cycles without any request moving
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    // directed rows: lattice points give zero noise, so with the reset offset of
    // 0.2 the brightness is floor(0.3^2 * 255) = 22
    t_vec vecs [] = '{
        '{'{4'd0,  4'd0,  26'h0},        1'b1, '{18'sd0, 8'd22}},
        '{'{4'd0,  4'd0,  26'h3FF0000},  1'b1, '{18'sd0, 8'd22}},
        '{'{4'd0,  4'd0,  26'h0010000},  1'b1, '{18'sd0, 8'd22}},
        '{'{4'd0,  4'd0,  26'h3FFFFFF},  1'b0, '{18'sd0, 8'd0}},
        '{'{4'd15, 4'd15, 26'h3FFFFFF},  1'b0, '{18'sd0, 8'd0}},
        '{'{4'd15, 4'd0,  26'h0},        1'b0, '{18'sd0, 8'd0}},
        '{'{4'd0,  4'd15, 26'h0},        1'b0, '{18'sd0, 8'd0}},
        '{'{4'd5,  4'd10, 26'h000FFFF},  1'b0, '{18'sd0, 8'd0}},
        '{'{4'd10, 4'd5,  26'h2A5A5A5},  1'b0, '{18'sd0, 8'd0}},
        '{'{4'd3,  4'd7,  26'h1208000},  1'b0, '{18'sd0, 8'd0}},
        '{'{4'd8,  4'd8,  26'h0008000},  1'b0, '{18'sd0, 8'd0}},
        '{'{4'd1,  4'd2,  26'h1555555},  1'b0, '{18'sd0, 8'd0}}
    };

    initial begin
        logic [15:0] set_x, set_y, set_o;
        t_shade      none;
        none.nv     = '0;
        none.bright = '0;
        step_x      = pnps_pkg::X_STEP_RST;
        step_y      = pnps_pkg::Y_STEP_RST;
        bright_ofs  = pnps_pkg::OFS_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (vecs[i]) send_pixel(vecs[i].px, vecs[i].known, vecs[i].shade);
        i_s_axis_tvalid <= 1'b0;

        // phases: all-zero, all-ones, reset values, then random settings
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: begin set_x = 16'h0000; set_y = 16'h0000; set_o = 16'h0000; end
                1: begin set_x = 16'hFFFF; set_y = 16'hFFFF; set_o = 16'hFFFF; end
                2: begin
                    set_x = pnps_pkg::X_STEP_RST;
                    set_y = pnps_pkg::Y_STEP_RST;
                    set_o = pnps_pkg::OFS_RST;
                end
                default: begin
                    set_x = 16'($urandom());
                    set_y = 16'($urandom());
                    set_o = ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom_range(32767));
                end
            endcase
            cfg_write(pnps_pkg::CFG_X_STEP, set_x);
            cfg_write(pnps_pkg::CFG_Y_STEP, set_y);
            cfg_write(pnps_pkg::CFG_BRIGHT_OFS, set_o);
            // a write to the spare index must leave every register alone
            if (ph == 2) cfg_write(CFG_NONE, 16'hFFFF);
            steady = (ph == 4);
            for (int k = 0; k < 235; k++) send_pixel(rand_pixel(), 1'b0, none);
            i_s_axis_tvalid <= 1'b0;
            steady = 1'b0;
        end

        wait (shade_q.size() == 0);
        repeat (LAT + 8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[filelist.f]
design/pnps_pkg.sv
design/perlin_noise_pixel_shader.sv
sim/tb_perlin_noise_pixel_shader.sv
